>>> design/pfpm_pkg.sv
// Package for the page frame pool manager: sizes, request and status codes,
// cell control types. Used by every design file but pfpm_if.
package pfpm_pkg;

    localparam int POOL_FRAMES = 16;
    localparam int FW = $clog2(POOL_FRAMES);
    localparam int CW = $clog2(POOL_FRAMES + 1);
    localparam logic [31:0] NO_PAGE = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        FN_FETCH = 3'd0, FN_NEW = 3'd1, FN_UNPIN = 3'd2,
        FN_DELETE = 3'd3, FN_FLUSH = 3'd4, FN_FLUSH_ALL = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NOT_RES = 3'd1, ST_NO_FRAME = 3'd2,
        ST_NOT_PINNED = 3'd3, ST_INVALID = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_APPLY, S_SCAN, S_OUT
    } state_t;

    // Command broadcast to the queue chain: pop head, remove an entry, append.
    typedef struct packed {
        logic          pop;
        logic          remove;
        logic [FW-1:0] rm_frame;
        logic          push;
        logic [FW-1:0] push_frame;
    } qcmd_t;

    typedef struct packed {
        logic [CW-1:0] count;
        logic [FW-1:0] head;
    } qstat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [FW-1:0] frame;
        logic [31:0] result_page;
        logic        write_back;
        logic [31:0] write_page;
        logic        read_in;
        logic        clear_frame;
        logic        last;
    } res_t;

endpackage

>>> design/pfpm_if.sv
// Valid/ready channel interfaces for requests, results and config writes.
interface pfpm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] page_id;
    logic        dirty;
    modport source (output valid, func, page_id, dirty, input ready);
    modport sink (input valid, func, page_id, dirty, output ready);
endinterface

interface pfpm_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  frame;
    logic [31:0] result_page;
    logic        write_back;
    logic [31:0] write_page;
    logic        read_in;
    logic        clear_frame;
    logic        last;
    modport source (output valid, status, frame, result_page, write_back,
                    write_page, read_in, clear_frame, last, input ready);
    modport sink (input valid, status, frame, result_page, write_back,
                  write_page, read_in, clear_frame, last, output ready);
endinterface

interface pfpm_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [8:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> design/pfpm_qcell.sv
// One slot of a shift queue of frame numbers; slots form a chain.
// Depends on pfpm_pkg.
module pfpm_qcell
    import pfpm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [FW-1:0] init_val,
    input  logic          shift_in,   // this slot takes its right neighbor
    input  logic          load,       // this slot takes the pushed frame
    input  logic [FW-1:0] nbr_val,
    input  logic [FW-1:0] push_val,
    output logic [FW-1:0] val
);
    logic [FW-1:0] val_reg, val_next;
    always_comb
    begin
        val_next = val_reg;
        if (load)
            val_next = push_val;
        else if (shift_in)
            val_next = nbr_val;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            val_reg <= init_val;
        else
            val_reg <= val_next;
    end
    assign val = val_reg;
endmodule

>>> design/pfpm_queue.sv
// Ordered queue of frame numbers built as a chain of slot cells; serves as
// both the free queue and the LRU order. Depends on pfpm_pkg, pfpm_qcell.
module pfpm_queue
    import pfpm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          init_full,
    input  qcmd_t         cmd,
    output qstat_t        stat
);
    logic [FW-1:0] vals [POOL_FRAMES];
    logic [CW-1:0] count_reg, count_next;
    logic [POOL_FRAMES-1:0] hit, past;
    logic [CW-1:0] after_cnt;

    // Slot i shifts when a removed entry sits at or before it.
    always_comb
    begin
        for (int i = 0; i < POOL_FRAMES; i++)
            hit[i] = (CW'(i) < count_reg) &&
                     ((cmd.pop && i == 0) || (cmd.remove && vals[i] == cmd.rm_frame));
        past[0] = hit[0];
        for (int i = 1; i < POOL_FRAMES; i++)
            past[i] = past[i-1] | hit[i];
        after_cnt = (past[POOL_FRAMES-1]) ? count_reg - 1'b1 : count_reg;
        count_next = after_cnt;
        if (cmd.push && after_cnt < CW'(POOL_FRAMES))
            count_next = after_cnt + 1'b1;
    end

    for (genvar g = 0; g < POOL_FRAMES; g++) begin : g_slot
        logic [FW-1:0] nbr;
        if (g == POOL_FRAMES - 1) begin : g_end
            assign nbr = vals[g];
        end else begin : g_mid
            assign nbr = vals[g+1];
        end
        pfpm_qcell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .init_val (init_full ? FW'(g) : '0),
            .shift_in (past[g]),
            .load     (cmd.push && after_cnt == CW'(g)),
            .nbr_val  (nbr),
            .push_val (cmd.push_frame),
            .val      (vals[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= init_full ? CW'(POOL_FRAMES) : '0;
        else
            count_reg <= count_next;
    end

    assign stat.count = count_reg;
    assign stat.head  = vals[0];

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(POOL_FRAMES)) else $error("queue count overflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_next > count_reg) |-> (count_next == count_reg + 1'b1))
        else $error("queue count jumped");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop && count_reg != '0) |=> (count_reg <= $past(count_reg)))
        else $error("pop did not shrink queue");
`endif
endmodule

>>> design/pfpm_fcell.sv
// One frame cell: page held, resident flag, pin count and dirty mark, plus
// its own page-id comparator. Depends on pfpm_pkg.
module pfpm_fcell
    import pfpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] cmp_page,
    input  logic        sel,        // this frame is the target of the update
    input  logic        do_load,    // bring a page in, pin 1, clean
    input  logic [31:0] load_page,
    input  logic        do_evict,   // drop residency
    input  logic        do_clear,   // delete: back to empty
    input  logic        pin_inc,
    input  logic        pin_dec,
    input  logic        set_dirty,
    input  logic        clr_dirty,
    output logic        match,
    output logic [31:0] page,
    output logic        res,
    output logic [15:0] pin,
    output logic        drt
);
    logic [31:0] page_reg, page_next;
    logic        res_reg, res_next, drt_reg, drt_next;
    logic [15:0] pin_reg, pin_next;

    always_comb
    begin
        page_next = page_reg;
        res_next  = res_reg;
        pin_next  = pin_reg;
        drt_next  = drt_reg;
        if (clr_dirty)
            drt_next = 1'b0;
        if (sel)
        begin
            if (do_evict)
                res_next = 1'b0;
            if (do_load)
            begin
                page_next = load_page;
                res_next  = 1'b1;
                pin_next  = 16'd1;
                drt_next  = 1'b0;
            end
            if (do_clear)
            begin
                page_next = NO_PAGE;
                res_next  = 1'b0;
                pin_next  = '0;
                drt_next  = 1'b0;
            end
            if (pin_inc && pin_reg != 16'hFFFF)
                pin_next = pin_reg + 16'd1;
            if (pin_dec)
                pin_next = pin_reg - 16'd1;
            if (set_dirty)
                drt_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg <= NO_PAGE;
            res_reg  <= 1'b0;
            pin_reg  <= '0;
            drt_reg  <= 1'b0;
        end
        else
        begin
            page_reg <= page_next;
            res_reg  <= res_next;
            pin_reg  <= pin_next;
            drt_reg  <= drt_next;
        end
    end

    assign match = res_reg && page_reg == cmp_page;
    assign page  = page_reg;
    assign res   = res_reg;
    assign pin   = pin_reg;
    assign drt   = drt_reg;
endmodule

>>> design/page_frame_pool_manager_top.sv
// Top level of the page frame pool manager: request sequencer over a row of
// frame cells and two queue chains. Depends on pfpm_pkg, pfpm_if, pfpm_fcell,
// pfpm_queue.
//
// Channels: req (func, page_id, dirty), res (one result per request, or one
// per dirty resident frame plus a closing beat for flush-all), cfg (index 0
// instance_count, index 1 instance_number; writing 1 reloads next_page).
// After a request beat is accepted, the sequencer steps through match and
// decide, apply (skipped for an invalid request) and present; the result beat
// is valid while presenting. The next request can be accepted in the cycle
// after the last result beat is taken, so no new request is taken before
// the last one is done. Flush-all walks one frame per cycle, pausing at dirty
// frames. The result register holds while res.ready is low; nothing advances.
// Reset empties every frame, fills the free queue with frames in order,
// empties the LRU order, and sets instance_count 1, instance_number 0.
module page_frame_pool_manager_top
    import pfpm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    pfpm_req_if.sink  req,
    pfpm_res_if.source res,
    pfpm_cfg_if.sink  cfg
);
    state_t state_reg, state_next;
    logic [2:0]  func_reg;
    logic [31:0] pid_reg;
    logic        dirty_reg;
    logic [8:0]  icount_reg;
    logic [31:0] next_page_reg;
    res_t        out_reg, out_next;
    logic [FW-1:0] scan_reg, scan_next;
    logic [FW-1:0] tgt_reg, tgt_next;
    logic          found_reg, found_next;

    logic [POOL_FRAMES-1:0] match, resv, drtv, sel;
    logic [31:0] pages [POOL_FRAMES];
    logic [15:0] pins  [POOL_FRAMES];
    logic        m_found;
    logic [FW-1:0] m_frame;

    qcmd_t fq_cmd, lq_cmd;
    qstat_t fq_stat, lq_stat;

    // cell controls
    logic c_load, c_evict, c_clear, c_inc, c_dec, c_setd;
    logic [POOL_FRAMES-1:0] c_clrd;
    logic [31:0] c_load_page;
    logic [FW-1:0] c_frame;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);

    for (genvar g = 0; g < POOL_FRAMES; g++) begin : g_frame
        pfpm_fcell u_fc (
            .clk (clk), .rst_n (rst_n), .cmp_page (pid_reg),
            .sel (sel[g]), .do_load (c_load), .load_page (c_load_page),
            .do_evict (c_evict), .do_clear (c_clear), .pin_inc (c_inc),
            .pin_dec (c_dec), .set_dirty (c_setd), .clr_dirty (c_clrd[g]),
            .match (match[g]), .page (pages[g]), .res (resv[g]),
            .pin (pins[g]), .drt (drtv[g])
        );
        assign sel[g] = (c_frame == FW'(g));
    end

    pfpm_queue u_freeq (.clk (clk), .rst_n (rst_n), .init_full (1'b1),
                        .cmd (fq_cmd), .stat (fq_stat));
    pfpm_queue u_lruq (.clk (clk), .rst_n (rst_n), .init_full (1'b0),
                       .cmd (lq_cmd), .stat (lq_stat));

    // Lowest matching frame.
    always_comb
    begin
        m_found = 1'b0;
        m_frame = '0;
        for (int i = POOL_FRAMES - 1; i >= 0; i--)
            if (match[i])
            begin
                m_found = 1'b1;
                m_frame = FW'(i);
            end
    end

    always_comb
    begin
        state_next = state_reg;
        out_next   = out_reg;
        scan_next  = scan_reg;
        tgt_next   = tgt_reg;
        found_next = found_reg;
        fq_cmd = '0;
        lq_cmd = '0;
        c_load = 1'b0; c_evict = 1'b0; c_clear = 1'b0;
        c_inc = 1'b0; c_dec = 1'b0; c_setd = 1'b0;
        c_clrd = '0;
        c_load_page = pid_reg;
        c_frame = tgt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                found_next = m_found;
                tgt_next   = m_frame;
                scan_next  = '0;
                if (func_reg > FN_FLUSH_ALL || (pid_reg[31] && func_reg != FN_NEW &&
                    func_reg != FN_FLUSH_ALL))
                begin
                    out_next = '{ST_INVALID, '0, NO_PAGE, 1'b0, NO_PAGE, 1'b0, 1'b0, 1'b1};
                    state_next = S_OUT;
                end
                else if (func_reg == FN_FLUSH_ALL)
                    state_next = S_SCAN;
                else
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = S_OUT;
                out_next = '{ST_OK, '0, NO_PAGE, 1'b0, NO_PAGE, 1'b0, 1'b0, 1'b1};
                if (func_reg == FN_FETCH && found_reg)
                begin
                    c_inc = 1'b1;
                    lq_cmd.remove = 1'b1;
                    lq_cmd.rm_frame = tgt_reg;
                    out_next.frame = tgt_reg;
                    out_next.result_page = pid_reg;
                end
                else if (func_reg == FN_FETCH || func_reg == FN_NEW)
                begin
                    if (fq_stat.count != '0)
                    begin
                        fq_cmd.pop = 1'b1;
                        c_frame = fq_stat.head;
                    end
                    else if (lq_stat.count != '0)
                    begin
                        lq_cmd.pop = 1'b1;
                        c_frame = lq_stat.head;
                        c_evict = 1'b1;
                        if (resv[lq_stat.head] && drtv[lq_stat.head])
                        begin
                            out_next.write_back = 1'b1;
                            out_next.write_page = pages[lq_stat.head];
                        end
                    end
                    else
                    begin
                        out_next.status = ST_NO_FRAME;
                        c_frame = tgt_reg;
                    end
                    if (fq_stat.count != '0 || lq_stat.count != '0)
                    begin
                        c_load = 1'b1;
                        out_next.frame = c_frame;
                        if (func_reg == FN_NEW)
                        begin
                            c_load_page = next_page_reg;
                            out_next.result_page = next_page_reg;
                            out_next.clear_frame = 1'b1;
                        end
                        else
                        begin
                            out_next.result_page = pid_reg;
                            out_next.read_in = 1'b1;
                        end
                    end
                end
                else if (func_reg == FN_UNPIN)
                begin
                    if (!found_reg)
                        out_next.status = ST_NOT_RES;
                    else
                    begin
                        out_next.frame = tgt_reg;
                        out_next.result_page = pid_reg;
                        if (pins[tgt_reg] == '0)
                            out_next.status = ST_NOT_PINNED;
                        else
                        begin
                            c_dec = 1'b1;
                            c_setd = dirty_reg;
                            if (pins[tgt_reg] == 16'd1)
                            begin
                                lq_cmd.push = 1'b1;
                                lq_cmd.push_frame = tgt_reg;
                            end
                        end
                    end
                end
                else if (func_reg == FN_DELETE)
                begin
                    if (found_reg)
                    begin
                        out_next.frame = tgt_reg;
                        if (pins[tgt_reg] != '0)
                        begin
                            out_next.status = ST_NO_FRAME;
                            out_next.result_page = pid_reg;
                        end
                        else
                        begin
                            c_clear = 1'b1;
                            lq_cmd.remove = 1'b1;
                            lq_cmd.rm_frame = tgt_reg;
                            fq_cmd.push = 1'b1;
                            fq_cmd.push_frame = tgt_reg;
                            out_next.clear_frame = 1'b1;
                            if (drtv[tgt_reg])
                            begin
                                out_next.write_back = 1'b1;
                                out_next.write_page = pages[tgt_reg];
                            end
                        end
                    end
                end
                else
                begin
                    if (!found_reg)
                        out_next.status = ST_NOT_RES;
                    else
                    begin
                        c_clrd[tgt_reg] = 1'b1;
                        out_next = '{ST_OK, tgt_reg, pid_reg, 1'b1, pid_reg,
                                     1'b0, 1'b0, 1'b1};
                    end
                end
            end
            S_SCAN:
            begin
                // Walk one frame per cycle; stop on a dirty resident frame.
                if (resv[scan_reg] && drtv[scan_reg])
                begin
                    c_clrd[scan_reg] = 1'b1;
                    out_next = '{ST_OK, scan_reg, pages[scan_reg], 1'b1,
                                 pages[scan_reg], 1'b0, 1'b0, 1'b0};
                    state_next = S_OUT;
                end
                else if (scan_reg == FW'(POOL_FRAMES - 1))
                begin
                    out_next = '{ST_OK, '0, NO_PAGE, 1'b0, NO_PAGE, 1'b0, 1'b0, 1'b1};
                    found_next = 1'b0;
                    state_next = S_OUT;
                end
                else
                    scan_next = scan_reg + 1'b1;
                if (resv[scan_reg] && drtv[scan_reg])
                    found_next = 1'b1;
            end
            S_OUT:
            begin
                if (res.ready)
                begin
                    if (out_reg.last)
                        state_next = S_IDLE;
                    else if (scan_reg == FW'(POOL_FRAMES - 1))
                        out_next = '{ST_OK, '0, NO_PAGE, 1'b0, NO_PAGE, 1'b0, 1'b0, 1'b1};
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            icount_reg    <= 9'd1;
            next_page_reg <= '0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            tgt_reg       <= '0;
            func_reg      <= '0;
            pid_reg       <= '0;
            dirty_reg     <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            found_reg <= found_next;
            tgt_reg   <= tgt_next;
            out_reg   <= out_next;
            if (req.valid && req.ready)
            begin
                func_reg  <= req.func;
                pid_reg   <= req.page_id;
                dirty_reg <= req.dirty;
            end
            if (cfg.valid && !cfg.index)
                icount_reg <= cfg.data;
            if (cfg.valid && cfg.index)
                next_page_reg <= {24'd0, cfg.data[7:0]};
            else if (state_reg == S_APPLY && func_reg == FN_NEW && c_load)
                next_page_reg <= next_page_reg +
                                 ((icount_reg == '0) ? 32'd1 : {23'd0, icount_reg});
        end
    end

    assign res.valid       = (state_reg == S_OUT);
    assign res.status      = out_reg.status;
    assign res.frame       = out_reg.frame;
    assign res.result_page = out_reg.result_page;
    assign res.write_back  = out_reg.write_back;
    assign res.write_page  = out_reg.write_page;
    assign res.read_in     = out_reg.read_in;
    assign res.clear_frame = out_reg.clear_frame;
    assign res.last        = out_reg.last;

`ifndef SYNTH
    a_one_hit_flush: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(c_clrd)) else $error("more than one dirty clear");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> !req.ready) else $error("accept while busy");
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && res.last) |=> (state_reg == S_IDLE))
        else $error("did not return to idle");
`endif
endmodule

>>> dv/pfpm_tb_if.sv
// Testbench copy of nothing: interfaces come from the design folder.
// This file holds small shared testbench types; depends on pfpm_pkg.
package pfpm_tb_pkg;
    import pfpm_pkg::*;

    typedef struct {
        func_t       func;
        logic [31:0] page_id;
        logic        dirty;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame;
        logic [31:0] result_page;
        logic        write_back;
        logic [31:0] write_page;
        logic        read_in;
        logic        clear_frame;
        logic        last;
    } answer_t;
endpackage

>>> dv/page_frame_pool_manager_top_tb.sv
// Testbench for page_frame_pool_manager_top: drives requests and config writes,
// predicts every result beat with a behavioral pool model and checks in order.
// Depends on pfpm_pkg, pfpm_tb_pkg and the interfaces in pfpm_if.
module page_frame_pool_manager_top_tb;
    import pfpm_pkg::*;
    import pfpm_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic clk;
    logic rst_n;

    pfpm_req_if req ();
    pfpm_res_if res ();
    pfpm_cfg_if cfg ();

    page_frame_pool_manager_top uut (
        .clk(clk), .rst_n(rst_n), .req(req), .res(res), .cfg(cfg)
    );

    // pool model state
    logic [31:0] pg_held [POOL_FRAMES];
    logic        pg_res [POOL_FRAMES];
    logic [15:0] pg_pins [POOL_FRAMES];
    logic        pg_dirty [POOL_FRAMES];
    int          free_frames [$];
    int          lru_frames [$];
    logic [8:0]  inst_count;
    logic [31:0] next_id;

    request_t pending_reqs [$];
    answer_t  expected_beats [$];
    logic [31:0] issued_ids [$];

    int mismatches;
    int beats_checked;
    int reqs_sent;
    int idle_cycles;
    int hold_res;

    bit quiet_phase;
    bit stall_phase;

    function automatic answer_t mk(logic [2:0] st, int fr, logic [31:0] rp, logic wb,
                                   logic [31:0] wp, logic ri, logic cf, logic lst);
        answer_t a;
        a.status = st; a.frame = fr[3:0]; a.result_page = rp; a.write_back = wb;
        a.write_page = wp; a.read_in = ri; a.clear_frame = cf; a.last = lst;
        return a;
    endfunction

    function automatic void expect_beat(answer_t a);
        expected_beats = {expected_beats, a};
    endfunction

    function automatic void queue_req(request_t r);
        pending_reqs = {pending_reqs, r};
    endfunction

    function automatic int find_frame(logic [31:0] pid);
        for (int f = 0; f < POOL_FRAMES; f++)
            if (pg_res[f] && pg_held[f] == pid)
                return f;
        return -1;
    endfunction

    function automatic void lru_drop(int fr);
        for (int i = 0; i < lru_frames.size(); i++)
            if (lru_frames[i] == fr)
            begin
                lru_frames.delete(i);
                return;
            end
    endfunction

    function automatic int grab_frame(output logic wb, output logic [31:0] wp);
        int fr;
        wb = 0;
        wp = NO_PAGE;
        if (free_frames.size() > 0)
        begin
            fr = free_frames[0];
            free_frames.delete(0);
            return fr;
        end
        if (lru_frames.size() > 0)
        begin
            fr = lru_frames[0];
            lru_frames.delete(0);
            if (pg_res[fr] && pg_dirty[fr])
            begin
                wb = 1;
                wp = pg_held[fr];
            end
            pg_res[fr] = 0;
            return fr;
        end
        return -1;
    endfunction

    function automatic void pool_reset();
        free_frames.delete();
        lru_frames.delete();
        for (int f = 0; f < POOL_FRAMES; f++)
        begin
            pg_held[f] = NO_PAGE; pg_res[f] = 0; pg_pins[f] = 0; pg_dirty[f] = 0;
            free_frames = {free_frames, f};
        end
        inst_count = 1;
        next_id = 0;
    endfunction

    function automatic void predict_pool(request_t r);
        int f;
        logic wb;
        logic [31:0] wp;
        logic [31:0] pid;
        pid = r.page_id;
        if (r.func > FN_FLUSH_ALL
            || (pid[31] && r.func != FN_NEW && r.func != FN_FLUSH_ALL))
        begin
            expect_beat(mk(ST_INVALID, 0, NO_PAGE, 0, NO_PAGE, 0, 0, 1));
            return;
        end
        case (r.func)
            FN_FETCH:
            begin
                f = find_frame(pid);
                if (f >= 0)
                begin
                    if (pg_pins[f] != 16'hFFFF) pg_pins[f]++;
                    lru_drop(f);
                    expect_beat(mk(ST_OK, f, pid, 0, NO_PAGE, 0, 0, 1));
                end
                else
                begin
                    f = grab_frame(wb, wp);
                    if (f < 0)
                        expect_beat(mk(ST_NO_FRAME, 0, NO_PAGE, 0, NO_PAGE, 0, 0, 1));
                    else
                    begin
                        pg_held[f] = pid; pg_res[f] = 1; pg_pins[f] = 1; pg_dirty[f] = 0;
                        expect_beat(mk(ST_OK, f, pid, wb, wp, 1, 0, 1));
                    end
                end
            end
            FN_NEW:
            begin
                f = grab_frame(wb, wp);
                if (f < 0)
                    expect_beat(mk(ST_NO_FRAME, 0, NO_PAGE, 0, NO_PAGE, 0, 0, 1));
                else
                begin
                    pid = next_id;
                    next_id += (inst_count == 0) ? 32'd1 : 32'(inst_count);
                    pg_held[f] = pid; pg_res[f] = 1; pg_pins[f] = 1; pg_dirty[f] = 0;
                    issued_ids = {issued_ids, pid};
                    expect_beat(mk(ST_OK, f, pid, wb, wp, 0, 1, 1));
                end
            end
            FN_UNPIN:
            begin
                f = find_frame(pid);
                if (f < 0)
                    expect_beat(mk(ST_NOT_RES, 0, NO_PAGE, 0, NO_PAGE, 0, 0, 1));
                else if (pg_pins[f] == 0)
                    expect_beat(mk(ST_NOT_PINNED, f, pid, 0, NO_PAGE, 0, 0, 1));
                else
                begin
                    pg_pins[f]--;
                    if (r.dirty) pg_dirty[f] = 1;
                    if (pg_pins[f] == 0 && !(f inside {lru_frames}))
                        lru_frames = {lru_frames, f};
                    expect_beat(mk(ST_OK, f, pid, 0, NO_PAGE, 0, 0, 1));
                end
            end
            FN_DELETE:
            begin
                f = find_frame(pid);
                if (f < 0)
                    expect_beat(mk(ST_OK, 0, NO_PAGE, 0, NO_PAGE, 0, 0, 1));
                else if (pg_pins[f] > 0)
                    expect_beat(mk(ST_NO_FRAME, f, pid, 0, NO_PAGE, 0, 0, 1));
                else
                begin
                    wb = pg_dirty[f];
                    wp = wb ? pg_held[f] : NO_PAGE;
                    lru_drop(f);
                    pg_res[f] = 0; pg_held[f] = NO_PAGE; pg_pins[f] = 0; pg_dirty[f] = 0;
                    free_frames = {free_frames, f};
                    expect_beat(mk(ST_OK, f, NO_PAGE, wb, wp, 0, 1, 1));
                end
            end
            FN_FLUSH:
            begin
                f = find_frame(pid);
                if (f < 0)
                    expect_beat(mk(ST_NOT_RES, 0, NO_PAGE, 0, NO_PAGE, 0, 0, 1));
                else
                begin
                    pg_dirty[f] = 0;
                    expect_beat(mk(ST_OK, f, pid, 1, pid, 0, 0, 1));
                end
            end
            default:
            begin
                for (int g = 0; g < POOL_FRAMES; g++)
                    if (pg_res[g] && pg_dirty[g])
                    begin
                        pg_dirty[g] = 0;
                        expect_beat(mk(ST_OK, g, pg_held[g], 1, pg_held[g], 0, 0, 0));
                    end
                expect_beat(mk(ST_OK, 0, NO_PAGE, 0, NO_PAGE, 0, 0, 1));
            end
        endcase
    endfunction

    function automatic request_t rq(int fn, logic [31:0] pid, int d);
        request_t r;
        r.func = func_t'(fn[2:0]);
        r.page_id = pid;
        r.dirty = d[0];
        return r;
    endfunction

    // pick a page id that is likely resident
    function automatic logic [31:0] pick_page();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7 && issued_ids.size() > 0)
            return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
        if (k == 7)
            return $urandom_range(0, 40);
        if (k == 8)
            return $urandom;
        return {1'b0, 31'($urandom)};
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 0;
            req.func <= '0;
            req.page_id <= '0;
            req.dirty <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_pool(pending_reqs[0]);
                pending_reqs.delete(0);
                reqs_sent++;
            end
            if (!req.valid || req.ready)
            begin
                if (!stall_phase && pending_reqs.size() > 0
                    && (quiet_phase || $urandom_range(0, 99) >= 26))
                begin
                    req.valid <= 1;
                    req.func <= pending_reqs[0].func;
                    req.page_id <= pending_reqs[0].page_id;
                    req.dirty <= pending_reqs[0].dirty;
                end
                else
                    req.valid <= 0;
            end
        end
    end

    // monitor and result sink
    always @(posedge clk or negedge rst_n)
    begin
        answer_t got, exp_b;
        if (!rst_n)
        begin
            res.ready <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got = mk(res.status, res.frame, res.result_page, res.write_back,
                         res.write_page, res.read_in, res.clear_frame, res.last);
                if (expected_beats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: status %0d frame %0d page %h",
                                 got.status, got.frame, got.result_page);
                end
                else
                begin
                    exp_b = expected_beats[0];
                    expected_beats.delete(0);
                    beats_checked++;
                    if (got !== exp_b)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: exp st%0d fr%0d rp%h wb%0d wp%h ri%0d cf%0d l%0d",
                                exp_b.status, exp_b.frame, exp_b.result_page,
                                exp_b.write_back, exp_b.write_page, exp_b.read_in,
                                exp_b.clear_frame, exp_b.last);
                            $display("          got st%0d fr%0d rp%h wb%0d wp%h ri%0d cf%0d l%0d",
                                got.status, got.frame, got.result_page, got.write_back,
                                got.write_page, got.read_in, got.clear_frame, got.last);
                        end
                    end
                end
            end
            if (hold_res > 0)
            begin
                hold_res--;
                res.ready <= 0;
            end
            else
                res.ready <= quiet_phase || $urandom_range(0, 99) >= 26;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (res.valid && res.ready)
                || (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("page_frame_pool_manager_top test failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req.valid || expected_beats.size() > 0)
            @(posedge clk);
        repeat (POOL_FRAMES + 10) @(posedge clk);
    endtask

    task automatic write_reg(int idx, int val);
        cfg.valid <= 1;
        cfg.index <= idx[0];
        cfg.data <= val[8:0];
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 0;
        if (idx == 0)
            inst_count = val[8:0];
        else
            next_id = {24'd0, val[7:0]};
        @(posedge clk);
    endtask

    task automatic add_random(int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 22) queue_req(rq(FN_FETCH, pick_page(), 0));
            else if (k < 38) queue_req(rq(FN_NEW, $urandom, 0));
            else if (k < 68) queue_req(rq(FN_UNPIN, pick_page(), $urandom_range(0, 1)));
            else if (k < 80) queue_req(rq(FN_DELETE, pick_page(), 0));
            else if (k < 90) queue_req(rq(FN_FLUSH, pick_page(), 0));
            else if (k < 95) queue_req(rq(FN_FLUSH_ALL, $urandom, 0));
            else if (k < 97) queue_req(rq($urandom_range(6, 7), $urandom,
                                          $urandom_range(0, 1)));
            else queue_req(rq(FN_FETCH, 32'hFFFF_FFFF, 1));
        end
    endtask

    initial
    begin
        rst_n = 0;
        req.valid = 0; req.func = '0; req.page_id = '0; req.dirty = 0;
        res.ready = 0;
        cfg.valid = 0; cfg.index = 0; cfg.data = '0;
        mismatches = 0; beats_checked = 0; reqs_sent = 0; idle_cycles = 0;
        hold_res = 0; quiet_phase = 0; stall_phase = 0;
        pool_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: invalid ids, unknown codes, fill the pool, exhaust it, evict
        queue_req(rq(FN_FETCH, 32'h8000_0000, 1));
        queue_req(rq(FN_UNPIN, 32'hFFFF_FFFF, 1));
        queue_req(rq(FN_DELETE, 32'hFFFF_FFFF, 0));
        queue_req(rq(FN_FLUSH, 32'hFFFF_FFFF, 0));
        queue_req(rq(6, 32'd5, 0));
        queue_req(rq(7, 32'd5, 1));
        queue_req(rq(FN_DELETE, 32'd77, 0));
        queue_req(rq(FN_UNPIN, 32'd77, 0));
        queue_req(rq(FN_FLUSH, 32'h7FFF_FFFF, 0));
        queue_req(rq(FN_FETCH, 32'h7FFF_FFFF, 0));
        queue_req(rq(FN_FETCH, 32'h7FFF_FFFF, 0));
        for (int i = 0; i < 15; i++)
            queue_req(rq(FN_NEW, 32'hFFFF_FFFF, 0));
        queue_req(rq(FN_NEW, 0, 0));
        queue_req(rq(FN_FETCH, 32'd999, 0));
        queue_req(rq(FN_DELETE, 32'd3, 0));
        queue_req(rq(FN_UNPIN, 32'd3, 1));
        queue_req(rq(FN_UNPIN, 32'd3, 0));
        queue_req(rq(FN_UNPIN, 32'h7FFF_FFFF, 1));
        queue_req(rq(FN_UNPIN, 32'h7FFF_FFFF, 0));
        queue_req(rq(FN_FLUSH_ALL, 0, 0));
        queue_req(rq(FN_UNPIN, 32'd1, 1));
        queue_req(rq(FN_FETCH, 32'd1000, 0));
        queue_req(rq(FN_DELETE, 32'd3, 0));
        wait_drained();

        // config: a large instance_count (256) and the largest next-page load (255)
        write_reg(0, 256);
        write_reg(1, 255);
        for (int i = 0; i < 16 && i < issued_ids.size(); i++)
            queue_req(rq(FN_UNPIN, issued_ids[i], $urandom_range(0, 1)));
        add_random(40);
        wait_drained();

        write_reg(0, 0);
        write_reg(1, 0);
        quiet_phase = 1;
        add_random(30);
        wait_drained();
        quiet_phase = 0;

        write_reg(0, $urandom_range(1, 255));
        write_reg(1, $urandom_range(0, 255));
        add_random(35);
        // receiver holds off while requests keep coming
        hold_res = 150;
        wait_drained();

        write_reg(0, 1);
        write_reg(1, 128);
        add_random(30);
        stall_phase = 1;
        while (expected_beats.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        stall_phase = 0;
        add_random(25);
        wait_drained();

        $display("%0d requests sent, %0d result beats checked over five register settings",
                 reqs_sent, beats_checked);
        if (mismatches == 0)
            $display("page_frame_pool_manager_top test passed");
        else
            $display("page_frame_pool_manager_top test failed");
        $finish;
    end
endmodule

>>> filelist.f
design/pfpm_pkg.sv
design/pfpm_if.sv
design/pfpm_qcell.sv
design/pfpm_queue.sv
design/pfpm_fcell.sv
design/page_frame_pool_manager_top.sv
dv/pfpm_tb_if.sv
dv/page_frame_pool_manager_top_tb.sv
